// File: rtl/cnlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types, constants and helpers for the card number classifier
// Digit-count bounds, double-dabble sizing and the Luhn digit mapping.
// ----------------------------------------------------------------------------
package cnlc_pkg;

	// input and result widths
	localparam int NUM_W  = 63;
	localparam int KIND_W = 2;

	// binary part converted to decimal: every accepted value is below 10^16 < 2^54
	localparam int BIN_W  = 54;
	localparam int DIGITS = 16;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int DAB_W  = BCD_W + BIN_W;

	// double-dabble stages and shift steps done in each
	localparam int DAB_STEPS  = 6;
	localparam int DAB_STAGES = BIN_W / DAB_STEPS;

	// decimal length bounds: 13 to 16 digits
	localparam logic [NUM_W-1:0] POW10_12 = 63'd1000000000000;
	localparam logic [NUM_W-1:0] POW10_13 = 63'd10000000000000;
	localparam logic [NUM_W-1:0] POW10_14 = 63'd100000000000000;
	localparam logic [NUM_W-1:0] POW10_15 = 63'd1000000000000000;
	localparam logic [NUM_W-1:0] POW10_16 = 63'd10000000000000000;

	// length code: digit count minus 13
	typedef logic [1:0] len_code_t;

	typedef logic [3:0] digit_t;
	typedef logic [4:0] pair_sum_t;
	typedef logic [7:0] total_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INVALID = 2'd0,
		KIND_P34_37  = 2'd1,
		KIND_P4      = 2'd2,
		KIND_P51_55  = 2'd3
	} card_kind_t;

	// prefix digits
	localparam digit_t DIG_1 = 4'd1;
	localparam digit_t DIG_3 = 4'd3;
	localparam digit_t DIG_4 = 4'd4;
	localparam digit_t DIG_5 = 4'd5;
	localparam digit_t DIG_7 = 4'd7;

	// run DAB_STEPS double-dabble steps over {bcd, binary}
	function automatic logic [DAB_W-1:0] dab_steps(input logic [DAB_W-1:0] v);
		logic [DAB_W-1:0] w;
		w = v;
		for (int s = 0; s < DAB_STEPS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (w[BIN_W + 4*d +: 4] >= 4'd5) begin
					w[BIN_W + 4*d +: 4] = w[BIN_W + 4*d +: 4] + 4'd3;
				end
			end
			w = {w[DAB_W-2:0], 1'b0};
		end
		return w;
	endfunction

	// Luhn doubled digit reduced to its digit sum
	function automatic digit_t luhn_double(input digit_t d);
		logic [4:0] dbl;
		dbl = {d, 1'b0};
		if (dbl > 5'd9) begin
			return digit_t'(dbl - 5'd9);
		end
		return digit_t'(dbl);
	endfunction

	// total is a multiple of ten
	function automatic logic is_mult10(input total_t t);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < 26; k++) begin
			if (t == total_t'(10 * k)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

// File: rtl/card_number_luhn_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_top: card number brand and Luhn classifier
// Counts decimal digits, checks the leading digits and runs the Luhn check.
// ----------------------------------------------------------------------------
//
//  channel      | direction | handshake                          | payload
//  -------------+-----------+------------------------------------+-------------------
//  card_number  | in        | card_number_valid / _ready         | card_number [62:0]
//  card_kind    | out       | card_kind_valid / _ready           | card_kind [1:0]
//
//  A 13-stage pipeline: a range stage, nine double-dabble stages of six bits each,
//  and three Luhn/prefix stages. One item may enter every cycle unless a stall on
//  card_kind has filled the pipeline. A stage advances when it is empty or the next
//  one advances, so a stall on card_kind holds every item in place, and bubbles
//  close up. Reset clears the valid bits only.
//
module card_number_luhn_classifier_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [cnlc_pkg::NUM_W-1:0]      card_number,
	input  wire                            card_number_valid,
	output logic                           card_number_ready,
	output logic [cnlc_pkg::KIND_W-1:0]    card_kind,
	output logic                           card_kind_valid,
	input  wire                            card_kind_ready
);
	import cnlc_pkg::*;

	localparam int NSTG  = DAB_STAGES + 4;
	localparam int ST_11 = DAB_STAGES + 1;
	localparam int ST_12 = DAB_STAGES + 2;
	localparam int ST_13 = DAB_STAGES + 3;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// advance chain: a stage moves when empty or its successor moves
	assign adv[NSTG-1] = !vld_q[NSTG-1] || card_kind_ready;
	genvar gi;
	generate
		for (gi = 0; gi < NSTG-1; gi++) begin : g_adv
			assign adv[gi] = !vld_q[gi] || adv[gi+1];
		end
	endgenerate

	assign card_number_ready = adv[0];
	assign card_kind_valid   = vld_q[NSTG-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= (i == 0) ? card_number_valid : vld_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	// stage 1: length range check and length code
	logic [BIN_W-1:0] num_s1;
	logic             ok_s1;
	len_code_t        len_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			num_s1 <= card_number[BIN_W-1:0];
			ok_s1  <= (card_number >= POW10_12) && (card_number < POW10_16);
			if (card_number >= POW10_15) begin
				len_s1 <= 2'd3;
			end else if (card_number >= POW10_14) begin
				len_s1 <= 2'd2;
			end else if (card_number >= POW10_13) begin
				len_s1 <= 2'd1;
			end else begin
				len_s1 <= 2'd0;
			end
		end
	end

	// stages 2 to 10: binary to decimal, six shift steps per stage
	logic [DAB_W-1:0] dab_s     [DAB_STAGES];
	logic             dab_ok_s  [DAB_STAGES];
	len_code_t        dab_len_s [DAB_STAGES];

	generate
		for (gi = 0; gi < DAB_STAGES; gi++) begin : g_dab
			if (gi == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (adv[1]) begin
						dab_s[0]     <= dab_steps({{BCD_W{1'b0}}, num_s1});
						dab_ok_s[0]  <= ok_s1;
						dab_len_s[0] <= len_s1;
					end
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					if (adv[gi+1]) begin
						dab_s[gi]     <= dab_steps(dab_s[gi-1]);
						dab_ok_s[gi]  <= dab_ok_s[gi-1];
						dab_len_s[gi] <= dab_len_s[gi-1];
					end
				end
			end
		end
	endgenerate

	// stage 11: leading digits, brand, Luhn digit mapping and pair sums
	logic [BCD_W-1:0] bcd;
	digit_t           lead_hi;
	digit_t           lead_lo;
	card_kind_t       kind_c;
	pair_sum_t        pair_c [DIGITS/2];

	assign bcd = dab_s[DAB_STAGES-1][DAB_W-1 -: BCD_W];

	always_comb begin
		case (dab_len_s[DAB_STAGES-1])
			2'd0:    begin lead_hi = bcd[4*12 +: 4]; lead_lo = bcd[4*11 +: 4]; end
			2'd1:    begin lead_hi = bcd[4*13 +: 4]; lead_lo = bcd[4*12 +: 4]; end
			2'd2:    begin lead_hi = bcd[4*14 +: 4]; lead_lo = bcd[4*13 +: 4]; end
			default: begin lead_hi = bcd[4*15 +: 4]; lead_lo = bcd[4*14 +: 4]; end
		endcase

		if (!dab_ok_s[DAB_STAGES-1]) begin
			kind_c = KIND_INVALID;
		end else if (lead_hi == DIG_3 && (lead_lo == DIG_4 || lead_lo == DIG_7)) begin
			kind_c = KIND_P34_37;
		end else if (lead_hi == DIG_4) begin
			kind_c = KIND_P4;
		end else if (lead_hi == DIG_5 && lead_lo >= DIG_1 && lead_lo <= DIG_5) begin
			kind_c = KIND_P51_55;
		end else begin
			kind_c = KIND_INVALID;
		end

		// least significant digit is kept, the next one doubled, and so on
		for (int p = 0; p < DIGITS/2; p++) begin
			pair_c[p] = pair_sum_t'(bcd[8*p +: 4]) + pair_sum_t'(luhn_double(bcd[8*p+4 +: 4]));
		end
	end

	card_kind_t kind_s11;
	pair_sum_t  pair_s11 [DIGITS/2];

	always_ff @(posedge clk) begin
		if (adv[ST_11]) begin
			kind_s11 <= kind_c;
			for (int p = 0; p < DIGITS/2; p++) begin
				pair_s11[p] <= pair_c[p];
			end
		end
	end

	// stage 12: add up the Luhn total
	total_t total_c;

	always_comb begin
		total_c = '0;
		for (int p = 0; p < DIGITS/2; p++) begin
			total_c = total_c + total_t'(pair_s11[p]);
		end
	end

	card_kind_t kind_s12;
	total_t     total_s12;

	always_ff @(posedge clk) begin
		if (adv[ST_12]) begin
			kind_s12  <= kind_s11;
			total_s12 <= total_c;
		end
	end

	// stage 13: checksum verdict into the output register
	card_kind_t kind_s13;

	always_ff @(posedge clk) begin
		if (adv[ST_13]) begin
			kind_s13 <= is_mult10(total_s12) ? kind_s12 : KIND_INVALID;
		end
	end

	assign card_kind = KIND_W'(kind_s13);

endmodule
`default_nettype wire
